// ===== rtl/ldp_pkg.sv =====
// ----------------------------------------------------------------------------
// ldp_pkg
// Shared types and constants of the LDP Kirsch code stream block: payload
// structs, window type, register indexes and sizing constants.
// ----------------------------------------------------------------------------
package ldp_pkg;

	// Image limits and derived counter widths
	localparam int MAX_WIDTH  = 1024;
	localparam int MAX_HEIGHT = 1024;
	localparam int COL_W      = $clog2(MAX_WIDTH);
	localparam int ROW_W      = $clog2(MAX_HEIGHT);

	// Field widths
	localparam int PIX_W   = 8;
	localparam int POS_W   = 10;
	localparam int CODE_W  = 8;
	localparam int WIDTH_W = 11;
	localparam int TOPK_W  = 4;

	// Line store entry: upper row byte over middle row byte
	localparam int LINE_W = 2 * PIX_W;

	// Window and arithmetic sizes
	localparam int WIN_N  = 9;
	localparam int NDIR   = 8;
	localparam int SUM3_W = PIX_W + 2;
	localparam int SUM8_W = PIX_W + 3;
	localparam int RESP_W = 15;
	localparam int MAG_W  = 13;

	// Output queue
	localparam int FIFO_DEPTH = 8;
	localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
	localparam int FIFO_CW    = FIFO_AW + 1;

	// Register port
	localparam int PADDR_W = 3;
	localparam int PDATA_W = 32;

	localparam logic [WIDTH_W-1:0] WIDTH_MIN   = 11'd3;
	localparam logic [WIDTH_W-1:0] WIDTH_MAX   = WIDTH_W'(MAX_WIDTH);
	localparam logic [WIDTH_W-1:0] WIDTH_RESET = 11'd640;
	localparam logic [TOPK_W-1:0]  TOPK_MIN    = 4'd1;
	localparam logic [TOPK_W-1:0]  TOPK_MAX    = 4'd8;
	localparam logic [TOPK_W-1:0]  TOPK_RESET  = 4'd3;

	typedef enum logic {
		REG_IMAGE_WIDTH = 1'b0,
		REG_TOP_COUNT   = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [PIX_W-1:0] pixel;
		logic             frame_start;
	} pix_in_t;

	typedef struct packed {
		logic [CODE_W-1:0] ldp_code;
		logic [POS_W-1:0]  center_row;
		logic [POS_W-1:0]  center_col;
	} code_out_t;

	typedef struct packed {
		logic [POS_W-1:0] center_row;
		logic [POS_W-1:0] center_col;
	} pos_t;

	// Window bytes, index row*3 + column, column 2 newest
	typedef logic [WIN_N-1:0][PIX_W-1:0] win_t;

endpackage

// ===== rtl/ldp_kirsch_code_stream_top.sv =====
// ----------------------------------------------------------------------------
// ldp_kirsch_code_stream_top
// Local Directional Pattern (Kirsch 3x3) code stream over a raster pixel feed.
// ----------------------------------------------------------------------------
// Usage:
//   pix_valid/pix_ready/pix_data carry one grey pixel per transfer in raster
//   order; frame_start on a pixel restarts row and column at zero.
//   code_valid/code_ready/code_data deliver one LDP code with its window
//   center for each pixel whose window lies fully inside the image (row and
//   column of the newest pixel both at least 2); border pixels give nothing.
//   image_width (byte address 0) and top_count (byte address 4) are written over the
//   APB port, by the user only while the stream is idle; the block does not check it.
// Path: a code is offered after its pixel passes stages s1 to s4 and the result queue.
// Throughput: one pixel per clock while pix_ready is high. The line store is a single
//   memory read at the pixel transfer and written back the next cycle, so one pixel
//   a cycle is what its one read and one write per cycle carry.
// Reset: counters clear, registers return to 640 and 3, the result queue
//   empties. The line store is not cleared; it needs no clearing pass.
// Stall: an 8-entry result queue takes codes while code_ready is low;
//   pix_ready drops once queued plus in-flight items reach 8.
// ----------------------------------------------------------------------------
module ldp_kirsch_code_stream_top (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        pix_valid,
	output logic                        pix_ready,
	input  ldp_pkg::pix_in_t            pix_data,
	output logic                        code_valid,
	input  logic                        code_ready,
	output ldp_pkg::code_out_t          code_data,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [ldp_pkg::PADDR_W-1:0] paddr,
	input  logic [ldp_pkg::PDATA_W-1:0] pwdata,
	output logic [ldp_pkg::PDATA_W-1:0] prdata,
	output logic                        pready
);
	import ldp_pkg::*;

	logic [WIDTH_W-1:0] image_width_q;
	logic [TOPK_W-1:0]  top_count_q;
	logic [COL_W-1:0]   column_count_q;
	logic [ROW_W-1:0]   row_count_q;
	logic               acc;
	logic               cfg_wr;
	reg_idx_t           reg_idx;
	logic [WIDTH_W-1:0] w_eff;
	logic [TOPK_W-1:0]  k_eff;
	logic [COL_W-1:0]   col_cur;
	logic [ROW_W-1:0]   row_cur;
	logic               row_end;
	logic               prod;
	pos_t               pos;
	logic               s1_busy;
	logic               win_valid;
	win_t               win;
	pos_t               win_pos;
	logic               s3_busy;
	logic               push;
	code_out_t          res;
	logic [FIFO_CW-1:0] level;
	logic [FIFO_CW:0]   pending;

	// Register port
	assign pready  = 1'b1;
	assign cfg_wr  = psel && penable && pwrite && pready;
	assign reg_idx = reg_idx_t'(paddr[PADDR_W-1]);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			image_width_q <= WIDTH_RESET;
			top_count_q   <= TOPK_RESET;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_IMAGE_WIDTH: image_width_q <= pwdata[WIDTH_W-1:0];
				REG_TOP_COUNT:   top_count_q   <= pwdata[TOPK_W-1:0];
				default:         ;
			endcase
		end
	end

	always_comb begin
		unique case (reg_idx)
			REG_IMAGE_WIDTH: prdata = PDATA_W'(image_width_q);
			REG_TOP_COUNT:   prdata = PDATA_W'(top_count_q);
			default:         prdata = '0;
		endcase
	end

	// Clamp register values into range
	always_comb begin
		if (image_width_q < WIDTH_MIN) begin
			w_eff = WIDTH_MIN;
		end else if (image_width_q > WIDTH_MAX) begin
			w_eff = WIDTH_MAX;
		end else begin
			w_eff = image_width_q;
		end
		if (top_count_q < TOPK_MIN) begin
			k_eff = TOPK_MIN;
		end else if (top_count_q > TOPK_MAX) begin
			k_eff = TOPK_MAX;
		end else begin
			k_eff = top_count_q;
		end
	end

	// Admit pixels while queue plus pipeline has room
	assign pending   = (FIFO_CW+1)'(level) + (FIFO_CW+1)'(s1_busy) + (FIFO_CW+1)'(win_valid)
	                 + (FIFO_CW+1)'(s3_busy) + (FIFO_CW+1)'(push);
	assign pix_ready = pending < (FIFO_CW+1)'(FIFO_DEPTH);
	assign acc       = pix_valid && pix_ready;

	// Raster position of the incoming pixel
	assign col_cur = pix_data.frame_start ? '0 : column_count_q;
	assign row_cur = pix_data.frame_start ? '0 : row_count_q;
	assign row_end = (WIDTH_W'(col_cur) + 1'b1) >= w_eff;
	assign prod    = (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
	assign pos.center_row = POS_W'(row_cur - 1'b1);
	assign pos.center_col = POS_W'(col_cur - 1'b1);

	// Advance column, wrap at row end, saturate the row
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			column_count_q <= '0;
			row_count_q    <= '0;
		end else if (acc) begin
			if (row_end) begin
				column_count_q <= '0;
				if (row_cur != ROW_W'(MAX_HEIGHT - 1)) begin
					row_count_q <= row_cur + 1'b1;
				end else begin
					row_count_q <= row_cur;
				end
			end else begin
				column_count_q <= col_cur + 1'b1;
				row_count_q    <= row_cur;
			end
		end
	end

	ldp_line_buf u_line (
		.clk       (clk),
		.arst_n    (arst_n),
		.acc       (acc),
		.pix       (pix_data.pixel),
		.col       (col_cur),
		.prod      (prod),
		.pos       (pos),
		.s1_busy   (s1_busy),
		.win_valid (win_valid),
		.win       (win),
		.win_pos   (win_pos)
	);

	ldp_code_calc u_calc (
		.clk       (clk),
		.arst_n    (arst_n),
		.win_valid (win_valid),
		.win       (win),
		.win_pos   (win_pos),
		.k         (k_eff),
		.s3_busy   (s3_busy),
		.push      (push),
		.res       (res)
	);

	ldp_out_fifo u_fifo (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (push),
		.wdata  (res),
		.pop    (code_valid && code_ready),
		.valid  (code_valid),
		.rdata  (code_data),
		.level  (level)
	);

	// Queue never overcommitted by admitted pixels
	a_credit: assert property (@(posedge clk) disable iff (!arst_n)
		pending <= (FIFO_CW+1)'(FIFO_DEPTH))
		else $error("result queue overcommitted");

	// Strongest direction is always marked
	a_code_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		code_valid |-> (code_data.ldp_code != '0))
		else $error("empty code offered");

endmodule

// ===== rtl/ldp_line_buf.sv =====
// ----------------------------------------------------------------------------
// ldp_line_buf
// Two-row line store in one synchronous memory, read-modify-write per pixel
// with forwarding on back-to-back hits, plus the 3x3 sliding window.
// ----------------------------------------------------------------------------
module ldp_line_buf (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     acc,
	input  logic [ldp_pkg::PIX_W-1:0] pix,
	input  logic [ldp_pkg::COL_W-1:0] col,
	input  logic                     prod,
	input  ldp_pkg::pos_t            pos,
	output logic                     s1_busy,
	output logic                     win_valid,
	output ldp_pkg::win_t            win,
	output ldp_pkg::pos_t            win_pos
);
	import ldp_pkg::*;

	logic [LINE_W-1:0] mem [MAX_WIDTH];
	logic [LINE_W-1:0] mem_rd_s1;
	logic [LINE_W-1:0] fwd_data_q;
	logic              fwd_q;
	logic              v_s1;
	logic [PIX_W-1:0]  px_s1;
	logic [COL_W-1:0]  col_s1;
	logic              prod_s1;
	pos_t              pos_s1;
	logic [LINE_W-1:0] rd_eff;
	logic [LINE_W-1:0] wr_data;
	logic              v_s2;
	win_t              win_q;
	pos_t              pos_s2;

	// Read on transfer, write back the rotated entry in the next cycle
	always_ff @(posedge clk) begin
		if (acc) begin
			mem_rd_s1 <= mem[col];
		end
		if (v_s1) begin
			mem[col_s1] <= wr_data;
		end
	end

	// Take the entry from the write in flight when both hit one column
	assign rd_eff  = fwd_q ? fwd_data_q : mem_rd_s1;
	assign wr_data = {rd_eff[PIX_W-1:0], px_s1};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fwd_q <= 1'b0;
			v_s1  <= 1'b0;
		end else begin
			fwd_q <= acc && v_s1 && (col == col_s1);
			v_s1  <= acc;
		end
	end

	// Hold pixel and position with the read
	always_ff @(posedge clk) begin
		if (acc) begin
			px_s1      <= pix;
			col_s1     <= col;
			prod_s1    <= prod;
			pos_s1     <= pos;
			fwd_data_q <= wr_data;
		end
	end

	// Shift the window left and load the new column
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			win_q <= '0;
			v_s2  <= 1'b0;
		end else begin
			v_s2 <= v_s1 && prod_s1;
			if (v_s1) begin
				for (int r = 0; r < 3; r++) begin
					win_q[r*3]     <= win_q[r*3 + 1];
					win_q[r*3 + 1] <= win_q[r*3 + 2];
				end
				win_q[2] <= rd_eff[LINE_W-1:PIX_W];
				win_q[5] <= rd_eff[PIX_W-1:0];
				win_q[8] <= px_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (v_s1) begin
			pos_s2 <= pos_s1;
		end
	end

	assign s1_busy   = v_s1;
	assign win_valid = v_s2;
	assign win       = win_q;
	assign win_pos   = pos_s2;

	// Forwarding only ever serves a live read-modify-write
	a_fwd_live: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_q |-> v_s1)
		else $error("forward flag without item in s1");

	// Every transfer reaches the write-back stage next cycle
	a_acc_s1: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> v_s1)
		else $error("accepted pixel lost before write-back");

endmodule

// ===== rtl/ldp_code_calc.sv =====
// ----------------------------------------------------------------------------
// ldp_code_calc
// Kirsch compass magnitudes of one window and the top-k directional code.
// Each response is 8*A - 3*T, A the sum of three ring neighbors, T all eight.
// ----------------------------------------------------------------------------
module ldp_code_calc (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       win_valid,
	input  ldp_pkg::win_t              win,
	input  ldp_pkg::pos_t              win_pos,
	input  logic [ldp_pkg::TOPK_W-1:0] k,
	output logic                       s3_busy,
	output logic                       push,
	output ldp_pkg::code_out_t         res
);
	import ldp_pkg::*;

	// Ring order clockwise from top left, as window indexes
	localparam logic [3:0] RING_IDX [NDIR] = '{4'd0, 4'd1, 4'd2, 4'd5, 4'd8, 4'd7, 4'd6, 4'd3};
	// First ring position of the three weight-5 taps, directions E..SE
	localparam logic [2:0] DIR_START [NDIR] = '{3'd2, 3'd1, 3'd0, 3'd7, 3'd6, 3'd5, 3'd4, 3'd3};

	logic [PIX_W-1:0]  ring [NDIR];
	logic [SUM3_W-1:0] a_c  [NDIR];
	logic [SUM8_W-1:0] t_c;
	logic [SUM3_W-1:0] a_s3 [NDIR];
	logic [SUM8_W-1:0] t_s3;
	pos_t              pos_s3;
	logic              v_s3;
	logic [MAG_W-1:0]  mag_c  [NDIR];
	logic [MAG_W-1:0]  mag_s4 [NDIR];
	pos_t              pos_s4;
	logic              v_s4;
	logic [CODE_W-1:0] code_c;

	// Gather ring neighbors and form partial sums
	always_comb begin
		logic [2:0] p0;
		logic [2:0] p1;
		logic [2:0] p2;
		t_c = '0;
		for (int i = 0; i < NDIR; i++) begin
			ring[i] = win[RING_IDX[i]];
			t_c     = t_c + SUM8_W'(ring[i]);
		end
		for (int m = 0; m < NDIR; m++) begin
			p0 = DIR_START[m];
			p1 = p0 + 3'd1;
			p2 = p0 + 3'd2;
			a_c[m] = SUM3_W'(ring[p0]) + SUM3_W'(ring[p1]) + SUM3_W'(ring[p2]);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
		end else begin
			v_s3 <= win_valid;
			v_s4 <= v_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (win_valid) begin
			a_s3   <= a_c;
			t_s3   <= t_c;
			pos_s3 <= win_pos;
		end
		if (v_s3) begin
			mag_s4 <= mag_c;
			pos_s4 <= pos_s3;
		end
	end

	// Response and magnitude per direction
	always_comb begin
		logic signed [RESP_W-1:0] resp;
		logic        [RESP_W-1:0] t3;
		for (int m = 0; m < NDIR; m++) begin
			t3       = RESP_W'(t_s3) + RESP_W'({t_s3, 1'b0});
			resp     = $signed(RESP_W'({a_s3[m], 3'b000})) - $signed(t3);
			mag_c[m] = resp[RESP_W-1] ? MAG_W'(-resp) : MAG_W'(resp);
		end
	end

	// Mark directions with fewer than k strictly larger magnitudes
	always_comb begin
		logic [2:0] greater;
		for (int m = 0; m < NDIR; m++) begin
			greater = '0;
			for (int j = 0; j < NDIR; j++) begin
				greater = greater + 3'(mag_s4[j] > mag_s4[m]);
			end
			code_c[m] = {1'b0, greater} < k;
		end
	end

	assign s3_busy        = v_s3;
	assign push           = v_s4;
	assign res.ldp_code   = code_c;
	assign res.center_row = pos_s4.center_row;
	assign res.center_col = pos_s4.center_col;

	// At least k directions always qualify
	a_topk: assert property (@(posedge clk) disable iff (!arst_n)
		v_s4 |-> ($countones(code_c) >= int'(k)))
		else $error("code marks fewer than top_count directions");

endmodule

// ===== rtl/ldp_out_fifo.sv =====
// ----------------------------------------------------------------------------
// ldp_out_fifo
// Result queue between the code pipeline and the output channel.
// ----------------------------------------------------------------------------
module ldp_out_fifo (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  ldp_pkg::code_out_t          wdata,
	input  logic                        pop,
	output logic                        valid,
	output ldp_pkg::code_out_t          rdata,
	output logic [ldp_pkg::FIFO_CW-1:0] level
);
	import ldp_pkg::*;

	code_out_t          fifo_q [FIFO_DEPTH];
	logic [FIFO_AW-1:0] wr_ptr_q;
	logic [FIFO_AW-1:0] rd_ptr_q;
	logic [FIFO_CW-1:0] cnt_q;

	// Store pushed results
	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= wdata;
		end
	end

	// Advance pointers and level
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			cnt_q <= cnt_q + FIFO_CW'(push) - FIFO_CW'(pop);
		end
	end

	assign valid = (cnt_q != '0);
	assign rdata = fifo_q[rd_ptr_q];
	assign level = cnt_q;

endmodule
